// File: rtl/cmt_pkg.sv
// Package for the Carmichael number test block.
// Holds the sequencer state type and the operation codes of the shared remainder unit.
// No dependencies.
`default_nettype none
package cmt_pkg;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b00000001,
        ST_SCAN    = 8'b00000010,
        ST_GCD_CHK = 8'b00000100,
        ST_MP_CHK  = 8'b00001000,
        ST_DIV     = 8'b00010000,
        ST_POST    = 8'b00100000,
        ST_FAC_CHK = 8'b01000000,
        ST_FINISH  = 8'b10000000
    } state_t;

    typedef enum logic [2:0] {
        OP_GCD  = 3'd0,
        OP_BASE = 3'd1,
        OP_ACC  = 3'd2,
        OP_SQ   = 3'd3,
        OP_FAC  = 3'd4
    } op_t;

endpackage
`default_nettype wire

// File: rtl/carmichael_number_test.sv
// Carmichael number test: Fermat scan over all coprime bases plus a compositeness check.
// Depends on cmt_pkg for the sequencer state type and the remainder operation codes.
//
//  channel | direction | ports                                         | meaning
//  --------+-----------+-----------------------------------------------+------------------
//  s_      | in        | s_valid, s_ready, s_number                    | candidate n
//  m_      | out       | m_valid, m_ready, m_fermat_pass, m_composite, | verdict for n
//          |           | m_is_carmichael                               |
//
// Every remainder (Euclid steps, modular reductions, trial division) runs through one
// restoring divider that retires one dividend bit per cycle.
// Reset (aresetn low at a clock edge) returns the sequencer to idle and drops m_valid.
// s_ready is high only while the sequencer is idle; a finished verdict waits in the output
// register, and the sequencer holds in its finish state until that register is free.
`default_nettype none
module carmichael_number_test #(
    parameter int NUM_WIDTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [NUM_WIDTH-1:0] s_number,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_fermat_pass,
    output logic                      m_composite,
    output logic                      m_is_carmichael
);
    import cmt_pkg::*;

    localparam int W     = NUM_WIDTH;
    localparam int CNT_W = $clog2(2 * NUM_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * NUM_WIDTH - 1);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [W-1:0]     n_reg, n_next;
    logic [W:0]       i_reg, i_next;      // base during the scan, trial divisor afterwards
    logic [W-1:0]     p_reg, p_next;
    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     sq_reg, sq_next;
    logic [W-1:0]     expo_reg, expo_next;
    logic [W-1:0]     m_reg, m_next;      // divisor of the shared unit
    logic [2*W-1:0]   div_reg, div_next;  // dividend, shifted out MSB first
    logic [W:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pass_reg, pass_next;
    logic             comp_reg, comp_next;
    logic             m_valid_reg, m_valid_next;
    logic             fp_reg, fp_next;
    logic             co_reg, co_next;

    // Shared datapath: one multiplier and one restoring division step.
    logic [W-1:0]   mul_a;
    logic [2*W-1:0] product;
    logic [W:0]     shift_w;
    logic [W:0]     sub_w;
    logic [W-1:0]   rem_res;

    assign mul_a   = (state_reg == ST_MP_CHK && expo_reg[0]) ? acc_reg : sq_reg;
    assign product = mul_a * sq_reg;
    assign shift_w = {rem_reg[W-1:0], div_reg[2*W-1]};
    assign sub_w   = shift_w - {1'b0, m_reg};
    assign rem_res = rem_reg[W-1:0];

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_fermat_pass   = fp_reg;
    assign m_composite     = co_reg;
    assign m_is_carmichael = fp_reg & co_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        expo_next    = expo_reg;
        m_next       = m_reg;
        div_next     = div_reg;
        rem_next     = '0;
        cnt_next     = '0;
        pass_next    = pass_reg;
        comp_next    = comp_reg;
        fp_next      = fp_reg;
        co_next      = co_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next     = s_number;
                    i_next     = (W+1)'(1);
                    pass_next  = 1'b1;
                    comp_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_reg > {1'b0, n_reg}) begin
                    i_next     = (W+1)'(2);
                    state_next = ST_FAC_CHK;
                end else begin
                    p_next     = n_reg;
                    q_next     = i_reg[W-1:0];
                    state_next = ST_GCD_CHK;
                end
            end
            ST_GCD_CHK: begin
                if (q_reg == '0) begin
                    if (p_reg == W'(1)) begin
                        // Coprime base: start the power with the base reduced mod n.
                        acc_next   = W'(1);
                        expo_next  = n_reg - W'(1);
                        div_next   = {{W{1'b0}}, i_reg[W-1:0]};
                        m_next     = n_reg;
                        op_next    = OP_BASE;
                        state_next = ST_DIV;
                    end else begin
                        i_next     = i_reg + (W+1)'(1);
                        state_next = ST_SCAN;
                    end
                end else begin
                    div_next   = {{W{1'b0}}, p_reg};
                    m_next     = q_reg;
                    op_next    = OP_GCD;
                    state_next = ST_DIV;
                end
            end
            ST_MP_CHK: begin
                if (expo_reg == '0) begin
                    if (acc_reg != W'(1)) begin
                        pass_next  = 1'b0;
                        i_next     = (W+1)'(2);
                        state_next = ST_FAC_CHK;
                    end else begin
                        i_next     = i_reg + (W+1)'(1);
                        state_next = ST_SCAN;
                    end
                end else begin
                    div_next   = product;
                    m_next     = n_reg;
                    op_next    = expo_reg[0] ? OP_ACC : OP_SQ;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = (shift_w >= {1'b0, m_reg}) ? sub_w : shift_w;
                div_next = {div_reg[2*W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                unique case (op_reg)
                    OP_GCD: begin
                        p_next     = q_reg;
                        q_next     = rem_res;
                        state_next = ST_GCD_CHK;
                    end
                    OP_BASE: begin
                        sq_next    = rem_res;
                        state_next = ST_MP_CHK;
                    end
                    OP_ACC: begin
                        // Multiply step done; square the running base next.
                        acc_next   = rem_res;
                        div_next   = product;
                        op_next    = OP_SQ;
                        state_next = ST_DIV;
                    end
                    OP_SQ: begin
                        sq_next    = rem_res;
                        expo_next  = expo_reg >> 1;
                        state_next = ST_MP_CHK;
                    end
                    OP_FAC: begin
                        if (rem_res == '0) begin
                            comp_next  = 1'b1;
                            state_next = ST_FINISH;
                        end else begin
                            i_next     = i_reg + (W+1)'(1);
                            state_next = ST_FAC_CHK;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_FAC_CHK: begin
                if (i_reg >= {1'b0, n_reg}) begin
                    state_next = ST_FINISH;
                end else begin
                    div_next   = {{W{1'b0}}, n_reg};
                    m_next     = i_reg[W-1:0];
                    op_next    = OP_FAC;
                    state_next = ST_DIV;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    fp_next      = pass_reg;
                    co_next      = comp_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_GCD;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        expo_reg <= expo_next;
        m_reg    <= m_next;
        div_reg  <= div_next;
        pass_reg <= pass_next;
        comp_reg <= comp_next;
        fp_reg   <= fp_next;
        co_reg   <= co_next;
    end

    // The sequencer is always in exactly one state.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // The partial remainder never reaches the divisor while a reduction runs.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg != '0) |-> (rem_reg < {1'b0, m_reg}))
        else $error("partial remainder not reduced");

    // An accepted request starts the scan on the following cycle.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start the scan");

endmodule
`default_nettype wire
